// ===== sv/smld_pkg.sv =====
`default_nettype none
package smld_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned MAX_BLOCKS   = 1024;
  localparam int unsigned POWER_W      = 48;
  localparam int unsigned RUN_W        = 42;
  localparam int unsigned BLOCK_W      = 35;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANS   = 3'd4;

  // 10*log10(2) in Q2.14
  localparam logic [31:0] DB_PER_LOG2 = 32'd49321;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         channel;
    logic               block_end;
    logic               arm_average;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         out_channel;
    logic signed [15:0] level_db;
    logic               last;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/sound_level_meter_db_core.sv =====
// A sample without block end passes through square, compare, two
//   partial products and update; in_ready is high again after that.
// Each level result takes two log evaluations (leading-one normalize,
//   then fraction squaring and scaling); all multiplications go through
//   one 32x32 multiplier.
// Reset (rst, synchronous): registers to 350/350/0/1/2, all power state,
//   sums and counters cleared, no output word pending.
`default_nettype none
module sound_level_meter_db_core
  import smld_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_DIFF, S_MLO, S_MHI, S_UPD,
    S_NORM, S_FSQ, S_FCHK, S_SCALE, S_LDONE, S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [23:0]        attack_coeff, release_coeff;
  logic signed [15:0] ref_offset_db;
  logic [10:0]        blocks_to_average;
  logic [3:0]         channel_count;

  // power state
  logic [POWER_W-1:0] smoothed_power [MAX_CHANNELS];
  logic [RUN_W-1:0]   running_power_sum [MAX_CHANNELS];
  logic [BLOCK_W-1:0] block_power_sum;
  logic [10:0]        blocks_summed;
  logic               averaging_armed;

  // working registers
  logic signed [15:0] smp;
  logic [2:0]         ch;
  logic               blk_end;
  logic               rise;
  logic [POWER_W-1:0] diff;
  logic [23:0]        acc;
  logic [63:0]        prod;
  logic [RUN_W-1:0]   norm;
  logic [5:0]         expo;
  logic [7:0]         frac;
  logic [2:0]         iter;
  logic [31:0]        mant;
  logic               lvl_phase;   // 0: numerator, 1: divisor
  logic [15:0]        lvl_num;
  logic signed [15:0] res;
  logic               avg_mode;
  logic               avg_go;
  logic [2:0]         avg_ch;

  // clamped config
  logic [3:0]  nch;
  logic [10:0] nblk;
  always_comb begin
    if (channel_count == 4'd0) nch = 4'd1;
    else if (channel_count > 4'(MAX_CHANNELS)) nch = 4'(MAX_CHANNELS);
    else nch = channel_count;
    if (blocks_to_average == 11'd0) nblk = 11'd1;
    else if (blocks_to_average > 11'(MAX_BLOCKS)) nblk = 11'(MAX_BLOCKS);
    else nblk = blocks_to_average;
  end

  // shared multiplier operands
  logic [16:0] mag;
  logic [23:0] coeff;
  logic [31:0] mul_a, mul_b;
  assign mag   = smp[15] ? 17'(-{smp[15], smp}) : {1'b0, smp};
  assign coeff = rise ? attack_coeff : release_coeff;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ:    begin mul_a = 32'(mag);   mul_b = 32'(mag); end
      S_MLO:   begin mul_a = 32'(coeff); mul_b = 32'(diff[23:0]); end
      S_MHI:   begin mul_a = 32'(coeff); mul_b = 32'(diff[47:24]); end
      S_FSQ:   begin mul_a = mant;       mul_b = mant; end
      S_SCALE: begin mul_a = 32'({expo, frac}); mul_b = DB_PER_LOG2; end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // smoother update and sums
  logic [POWER_W-1:0] x_pow, y_old, step, y_new;
  logic [31:0]        ip;
  logic [BLOCK_W:0]   bsum_wide;
  logic [BLOCK_W-1:0] bsum_new;
  logic [RUN_W:0]     rsum_wide;
  logic [RUN_W-1:0]   rsum_new;
  logic [10:0]        bs_inc;
  logic               last_ch;
  logic [32:0]        sq_t;
  logic signed [17:0] lv;

  assign x_pow     = {prod[31:0], 16'd0};
  assign y_old     = smoothed_power[ch];
  assign step      = prod[47:0] + 48'(acc);
  assign y_new     = rise ? (y_old + step) : (y_old - step);
  assign ip        = y_new[47:16];
  assign bsum_wide = {1'b0, block_power_sum} + (BLOCK_W+1)'(ip);
  assign bsum_new  = bsum_wide[BLOCK_W] ? '1 : bsum_wide[BLOCK_W-1:0];
  assign rsum_wide = {1'b0, running_power_sum[ch]} + (RUN_W+1)'(ip);
  assign rsum_new  = rsum_wide[RUN_W] ? '1 : rsum_wide[RUN_W-1:0];
  assign bs_inc    = blocks_summed + 11'd1;
  assign last_ch   = ({1'b0, ch} == nch - 4'd1);
  assign sq_t      = prod[63:31];
  assign lv        = $signed({2'b00, lvl_num}) - $signed({2'b00, prod[29:14]})
                     - $signed({{2{ref_offset_db[15]}}, ref_offset_db});

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  function automatic logic last_avg();
    return ({1'b0, avg_ch} == nch - 4'd1);
  endfunction

  // zero reads as one for the log
  function automatic logic [RUN_W-1:0] nz(input logic [RUN_W-1:0] v);
    return (v == '0) ? RUN_W'(1) : v;
  endfunction

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state             <= S_IDLE;
      attack_coeff      <= 24'd350;
      release_coeff     <= 24'd350;
      ref_offset_db     <= '0;
      blocks_to_average <= 11'd1;
      channel_count     <= 4'd2;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        smoothed_power[i]    <= '0;
        running_power_sum[i] <= '0;
      end
      block_power_sum <= '0;
      blocks_summed   <= '0;
      averaging_armed <= 1'b0;
      out_valid       <= 1'b0;
      avg_mode        <= 1'b0;
      avg_go          <= 1'b0;
      lvl_phase       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ATTACK:  attack_coeff      <= cfg_data;
          REG_RELEASE: release_coeff     <= cfg_data;
          REG_REF:     ref_offset_db     <= cfg_data[15:0];
          REG_BLOCKS:  blocks_to_average <= cfg_data[10:0];
          REG_CHANS:   channel_count     <= cfg_data[3:0];
          default: ;
        endcase
      end
      // S_EMIT reloads the output register itself
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp     <= in_data.sample;
            ch      <= in_data.channel;
            blk_end <= in_data.block_end;
            if (in_data.arm_average) averaging_armed <= 1'b1;
            if ({1'b0, in_data.channel} < nch) state <= S_SQ;
          end
        end
        S_SQ: state <= S_DIFF;
        S_DIFF: begin
          rise  <= (x_pow > y_old);
          diff  <= (x_pow > y_old) ? (x_pow - y_old) : (y_old - x_pow);
          state <= S_MLO;
        end
        S_MLO: state <= S_MHI;
        S_MHI: begin
          acc   <= prod[47:24];
          state <= S_UPD;
        end
        S_UPD: begin
          smoothed_power[ch] <= y_new;
          state <= (blk_end && last_ch) ? S_NORM : S_IDLE;
          if (blk_end) begin
            if (averaging_armed) running_power_sum[ch] <= rsum_new;
            block_power_sum <= last_ch ? '0 : bsum_new;
            if (last_ch) begin
              norm      <= (bsum_new == '0) ? RUN_W'(1) : RUN_W'(bsum_new);
              expo      <= 6'(RUN_W - 1);
              lvl_phase <= 1'b0;
              avg_mode  <= 1'b0;
              avg_go    <= 1'b0;
              if (averaging_armed) begin
                if (bs_inc >= nblk) begin
                  avg_go          <= 1'b1;
                  blocks_summed   <= '0;
                  averaging_armed <= 1'b0;
                end else begin
                  blocks_summed <= bs_inc;
                end
              end
            end
          end
        end
        // leading one: one bit per cycle
        S_NORM: begin
          if (norm[RUN_W-1]) begin
            mant  <= norm[RUN_W-1 -: 32];
            iter  <= '0;
            frac  <= '0;
            state <= S_FSQ;
          end else begin
            norm <= norm << 1;
            expo <= expo - 6'd1;
          end
        end
        S_FSQ: state <= S_FCHK;
        S_FCHK: begin
          frac <= {frac[6:0], sq_t[32]};
          mant <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
          iter <= iter + 3'd1;
          state <= (iter == 3'd7) ? S_SCALE : S_FSQ;
        end
        S_SCALE: state <= S_LDONE;
        S_LDONE: begin
          if (!lvl_phase) begin
            lvl_num   <= prod[29:14];
            lvl_phase <= 1'b1;
            norm      <= avg_mode ? RUN_W'(nblk) : RUN_W'(nch);
            expo      <= 6'(RUN_W - 1);
            state     <= S_NORM;
          end else begin
            if (lv > 18'sd32767) res <= 16'sh7FFF;
            else if (lv < -18'sd32768) res <= 16'sh8000;
            else res <= lv[15:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.kind        <= avg_mode;
            out_data.out_channel <= avg_mode ? avg_ch : 3'd0;
            out_data.level_db    <= res;
            out_data.last        <= avg_mode ? last_avg() : !avg_go;
            lvl_phase            <= 1'b0;
            expo                 <= 6'(RUN_W - 1);
            if (!avg_mode && avg_go) begin
              avg_mode             <= 1'b1;
              avg_ch               <= 3'd0;
              norm                 <= nz(running_power_sum[0]);
              running_power_sum[0] <= '0;
              state                <= S_NORM;
            end else if (avg_mode && !last_avg()) begin
              avg_ch                          <= avg_ch + 3'd1;
              norm                            <= nz(running_power_sum[avg_ch + 3'd1]);
              running_power_sum[avg_ch + 3'd1] <= '0;
              state                           <= S_NORM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    !averaging_armed |-> blocks_summed == '0) else $error("count kept while disarmed");
  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    state == S_FSQ |-> mant[31]) else $error("mantissa not normalized");
  a_kind0_ch: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.kind |-> out_data.out_channel == 3'd0)
    else $error("block level with channel");
  a_avg_ch: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && avg_mode |-> {1'b0, avg_ch} < nch) else $error("channel past count");

endmodule
`default_nettype wire
